@@ hw/rtl/r2fft_pkg.sv @@
// Shared types for the radix-2 FFT engine.
// No dependencies; the top level takes items by scoped names.
package r2fft_pkg;

  // Sequencer states of the FFT engine.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_BR_A,
    ST_BR_B,
    ST_BR_C,
    ST_BR_D,
    ST_TW,
    ST_BF_RDB,
    ST_BF_RDA,
    ST_BF_M0,
    ST_BF_M1,
    ST_BF_M2,
    ST_BF_M3,
    ST_BF_M4,
    ST_BF_WB,
    ST_BF_WA
  } state_e;

endpackage

@@ hw/rtl/r2fft_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module r2fft_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/radix2_fft_engine_top.sv @@
// Radix-2 decimation-in-time FFT engine: load, in-place transform, bin read.
// Depends on r2fft_pkg (states) and r2fft_ram (work store).
//
// Channel      Direction  Signals
// request      in         start, busy, op_i, sample_i, bin_index_i
// result       out        result_strobe_o, bin_real_o, bin_imag_o, bin_echo_o, status_o
// config       in         cfg_we_i, cfg_wdata_i (fft_exp)
//
// The load that fills the frame keeps busy high for the bit-reverse pass, which swaps
// each pair through the RAM, and for the butterfly stages, where one shared multiplier
// and the single RAM port pair serve each butterfly in turn, after a twiddle step per
// twiddle. A read issues the RAM read and then raises the result strobe.
// Reset clears the sequencer, the load count and the frame flag; the store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module radix2_fft_engine_top #(
  parameter int MAX_POINTS_LOG2   = 10,
  parameter int SAMPLE_BITS       = 16,
  parameter int TWIDDLE_FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   op_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  input  logic [9:0]                             bin_index_i,
  output logic                                   result_strobe_o,
  output logic signed [SAMPLE_BITS+MAX_POINTS_LOG2-1:0] bin_real_o,
  output logic signed [SAMPLE_BITS+MAX_POINTS_LOG2-1:0] bin_imag_o,
  output logic [9:0]                             bin_echo_o,
  output logic                                   status_o,
  input  logic                                   cfg_we_i,
  input  logic [3:0]                             cfg_wdata_i
);

  localparam int M   = MAX_POINTS_LOG2;
  localparam int S   = SAMPLE_BITS;
  localparam int F   = TWIDDLE_FRAC_BITS;
  localparam int WB  = S + M + 1;
  localparam int OB  = S + M;
  localparam int TW  = F + 2;
  localparam int LW  = $clog2(M + 1);
  localparam int TSZ = ((M >= 3) ? (1 << (M - 3)) : 1) + 1;
  localparam int TIW = $clog2(TSZ);
  localparam int PW  = TW + WB + 1;
  localparam int RW  = WB + 2;
  localparam logic signed [RW:0] WMAX = {4'b0000, {(WB - 1){1'b1}}};
  localparam logic signed [RW:0] WMIN = {4'b1111, {(WB - 1){1'b0}}};
  localparam real TW_STEP = 2.0 * 3.14159265358979323846 / (2.0 ** M);

  // Octant twiddle value, rounded to nearest at F fractional bits.
  function automatic longint tw_val(input int t, input bit sel_sin);
    real phi;
    real v;
    phi = TW_STEP * real'(t);
    v   = sel_sin ? $sin(phi) : $cos(phi);
    return longint'($floor(v * (2.0 ** F) + 0.5));
  endfunction

  // Saturate a butterfly sum to the work width.
  function automatic logic signed [WB-1:0] sat_w(input logic signed [RW:0] v);
    if (v > WMAX) return WMAX[WB-1:0];
    if (v < WMIN) return WMIN[WB-1:0];
    return v[WB-1:0];
  endfunction

  // Saturate a stored value to the output width.
  function automatic logic signed [OB-1:0] sat_o(input logic signed [WB-1:0] v);
    if (v[WB-1] != v[WB-2]) return v[WB-1] ? {1'b1, {(OB - 1){1'b0}}} : {1'b0, {(OB - 1){1'b1}}};
    return v[OB-1:0];
  endfunction

  // Constant octant tables of cosine and sine.
  logic signed [TW-1:0] cos_tab [TSZ];
  logic signed [TW-1:0] sin_tab [TSZ];
  for (genvar g = 0; g < TSZ; g++) begin : g_tab
    assign cos_tab[g] = TW'(tw_val(g, 1'b0));
    assign sin_tab[g] = TW'(tw_val(g, 1'b1));
  end

  r2fft_pkg::state_e state_q, state_d;

  logic [3:0]   fft_exp_q;
  logic [M:0]   cnt_q, cnt_d;
  logic         done_q, done_d;
  logic [M-1:0] i_q, i_d;
  logic [LW-1:0] lv_q, lv_d;
  logic [M-1:0] j_q, j_d;
  logic [M-1:0] base_q, base_d;
  logic [9:0]   echo_q, echo_d;
  logic         stat_q, stat_d;

  logic signed [TW-1:0] c_q, c_d, s_q, s_d;
  logic signed [WB-1:0] br_q, bi_q, ar_q, ai_q;
  logic signed [PW-1:0] p_q, acc_q;
  logic signed [RW-1:0] tr_q, ti_q;
  logic [2*WB-1:0]      ra_q;

  // Effective exponent and frame size.
  logic [LW-1:0] e_w;
  logic [M:0]    n_w;
  logic [M-1:0]  nm1_w;
  always_comb begin
    if (fft_exp_q == 4'd0) begin
      e_w = LW'(1);
    end else if (int'(fft_exp_q) > M) begin
      e_w = LW'(M);
    end else begin
      e_w = LW'(fft_exp_q);
    end
    n_w   = (M + 1)'(1) << e_w;
    nm1_w = M'(n_w - (M + 1)'(1));
  end

  // Bit-reversed partner of i over e bits.
  logic [M-1:0] rev_full, j_rev;
  always_comb begin
    for (int b = 0; b < M; b++) begin
      rev_full[b] = i_q[M-1-b];
    end
    j_rev = rev_full >> (LW'(M) - e_w);
  end

  // Butterfly geometry.
  logic [M-1:0] half_w, bh_w;
  logic [M:0]   bnext_w, jnext_w;
  always_comb begin
    half_w  = M'(1) << (lv_q - LW'(1));
    bh_w    = base_q + half_w;
    bnext_w = {1'b0, base_q} + {half_w, 1'b0};
    jnext_w = {1'b0, j_q} + (M + 1)'(1);
  end

  // Twiddle fold: quadrant, octant swap, table index.
  logic [31:0]  u_w;
  logic [29:0]  r_w, rp_w;
  logic [30:0]  rdif_w;
  logic         swap_w, quad_w;
  logic [TIW-1:0] tix_w;
  logic signed [TW-1:0] tc_w, ts_w, sc_w, ss_w;
  always_comb begin
    u_w    = 32'(j_q) << (6'd32 - 6'(lv_q));
    quad_w = u_w[30];
    r_w    = u_w[29:0];
    swap_w = r_w > 30'h2000_0000;
    rdif_w = 31'h4000_0000 - {1'b0, r_w};
    rp_w   = swap_w ? rdif_w[29:0] : r_w;
    tix_w  = TIW'(rp_w >> (32 - M));
    tc_w   = cos_tab[tix_w];
    ts_w   = sin_tab[tix_w];
    sc_w   = swap_w ? ts_w : tc_w;
    ss_w   = swap_w ? tc_w : ts_w;
    c_d    = quad_w ? -ss_w : sc_w;
    s_d    = quad_w ? sc_w : ss_w;
  end

  // Shared multiplier and rounding adder.
  logic signed [TW-1:0]    ma_w;
  logic signed [WB-1:0]    mb_w;
  logic signed [TW+WB-1:0] prod_w;
  logic signed [PW-1:0]    rsum_w;
  logic signed [PW-1:0]    rsh_w;
  logic signed [PW-1:0]    acc_d;
  always_comb begin
    ma_w = c_q;
    mb_w = br_q;
    case (state_q)
      r2fft_pkg::ST_BF_M1: begin ma_w = s_q; mb_w = bi_q; end
      r2fft_pkg::ST_BF_M2: begin ma_w = c_q; mb_w = bi_q; end
      r2fft_pkg::ST_BF_M3: begin ma_w = s_q; mb_w = br_q; end
      default:             begin ma_w = c_q; mb_w = br_q; end
    endcase
    prod_w = ma_w * mb_w;
    acc_d  = (state_q == r2fft_pkg::ST_BF_M4) ? (acc_q - p_q) : (acc_q + p_q);
    rsum_w = acc_d + (PW'(1) << (F - 1));
    rsh_w  = rsum_w >>> F;
  end

  // RAM ports.
  logic                we_w;
  logic [M-1:0]        waddr_w, raddr_w;
  logic [2*WB-1:0]     wdata_w, rdata_w;
  logic signed [WB-1:0] rd_re_w, rd_im_w;
  logic [M-1:0]        lidx_w;
  assign rd_re_w = rdata_w[2*WB-1:WB];
  assign rd_im_w = rdata_w[WB-1:0];

  r2fft_ram #(
    .WIDTH(2 * WB),
    .DEPTH(1 << M)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_w),
    .waddr_i(waddr_w),
    .wdata_i(wdata_w),
    .raddr_i(raddr_w),
    .rdata_o(rdata_w)
  );

  assign busy            = (state_q != r2fft_pkg::ST_IDLE);
  assign result_strobe_o = (state_q == r2fft_pkg::ST_READ);
  assign bin_echo_o      = echo_q;
  assign status_o        = stat_q;
  assign bin_real_o      = stat_q ? '0 : sat_o(rd_re_w);
  assign bin_imag_o      = stat_q ? '0 : sat_o(rd_im_w);

  // Sequencer: next state, counters and RAM control.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    i_d     = i_q;
    lv_d    = lv_q;
    j_d     = j_q;
    base_d  = base_q;
    echo_d  = echo_q;
    stat_d  = stat_q;
    we_w    = 1'b0;
    waddr_w = '0;
    wdata_w = '0;
    raddr_w = '0;
    lidx_w  = (done_q || (cnt_q >= n_w)) ? '0 : cnt_q[M-1:0];
    case (state_q)
      r2fft_pkg::ST_IDLE: begin
        raddr_w = M'(bin_index_i) & nm1_w;
        if (start) begin
          if (op_i) begin
            echo_d  = bin_index_i;
            stat_d  = !done_q;
            state_d = r2fft_pkg::ST_READ;
          end else begin
            we_w    = 1'b1;
            waddr_w = lidx_w;
            wdata_w = {{(WB - S){sample_i[S-1]}}, sample_i, {WB{1'b0}}};
            cnt_d   = {1'b0, lidx_w} + (M + 1)'(1);
            done_d  = 1'b0;
            if (cnt_d == n_w) begin
              i_d     = '0;
              state_d = r2fft_pkg::ST_BR_A;
            end
          end
        end
      end
      r2fft_pkg::ST_READ: begin
        state_d = r2fft_pkg::ST_IDLE;
      end
      r2fft_pkg::ST_BR_A: begin
        raddr_w = i_q;
        if (i_q < j_rev) begin
          state_d = r2fft_pkg::ST_BR_B;
        end else if (i_q == nm1_w) begin
          lv_d    = LW'(1);
          j_d     = '0;
          base_d  = '0;
          state_d = r2fft_pkg::ST_TW;
        end else begin
          i_d = i_q + M'(1);
        end
      end
      r2fft_pkg::ST_BR_B: begin
        raddr_w = j_rev;
        state_d = r2fft_pkg::ST_BR_C;
      end
      r2fft_pkg::ST_BR_C: begin
        we_w    = 1'b1;
        waddr_w = i_q;
        wdata_w = rdata_w;
        state_d = r2fft_pkg::ST_BR_D;
      end
      r2fft_pkg::ST_BR_D: begin
        we_w    = 1'b1;
        waddr_w = j_rev;
        wdata_w = ra_q;
        if (i_q == nm1_w) begin
          lv_d    = LW'(1);
          j_d     = '0;
          base_d  = '0;
          state_d = r2fft_pkg::ST_TW;
        end else begin
          i_d     = i_q + M'(1);
          state_d = r2fft_pkg::ST_BR_A;
        end
      end
      r2fft_pkg::ST_TW: begin
        state_d = r2fft_pkg::ST_BF_RDB;
      end
      r2fft_pkg::ST_BF_RDB: begin
        raddr_w = bh_w;
        state_d = r2fft_pkg::ST_BF_RDA;
      end
      r2fft_pkg::ST_BF_RDA: begin
        raddr_w = base_q;
        state_d = r2fft_pkg::ST_BF_M0;
      end
      r2fft_pkg::ST_BF_M0: state_d = r2fft_pkg::ST_BF_M1;
      r2fft_pkg::ST_BF_M1: state_d = r2fft_pkg::ST_BF_M2;
      r2fft_pkg::ST_BF_M2: state_d = r2fft_pkg::ST_BF_M3;
      r2fft_pkg::ST_BF_M3: state_d = r2fft_pkg::ST_BF_M4;
      r2fft_pkg::ST_BF_M4: state_d = r2fft_pkg::ST_BF_WB;
      r2fft_pkg::ST_BF_WB: begin
        we_w    = 1'b1;
        waddr_w = bh_w;
        wdata_w = {sat_w((RW + 1)'(ar_q) - (RW + 1)'(tr_q)),
                   sat_w((RW + 1)'(ai_q) - (RW + 1)'(ti_q))};
        state_d = r2fft_pkg::ST_BF_WA;
      end
      r2fft_pkg::ST_BF_WA: begin
        we_w    = 1'b1;
        waddr_w = base_q;
        wdata_w = {sat_w((RW + 1)'(ar_q) + (RW + 1)'(tr_q)),
                   sat_w((RW + 1)'(ai_q) + (RW + 1)'(ti_q))};
        if (bnext_w < n_w) begin
          base_d  = bnext_w[M-1:0];
          state_d = r2fft_pkg::ST_BF_RDB;
        end else if (jnext_w < {1'b0, half_w}) begin
          j_d     = jnext_w[M-1:0];
          base_d  = jnext_w[M-1:0];
          state_d = r2fft_pkg::ST_TW;
        end else if (lv_q < e_w) begin
          lv_d    = lv_q + LW'(1);
          j_d     = '0;
          base_d  = '0;
          state_d = r2fft_pkg::ST_TW;
        end else begin
          done_d  = 1'b1;
          state_d = r2fft_pkg::ST_IDLE;
        end
      end
      default: state_d = r2fft_pkg::ST_IDLE;
    endcase
    // A register write restarts the frame.
    if (cfg_we_i) begin
      cnt_d  = '0;
      done_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= r2fft_pkg::ST_IDLE;
      fft_exp_q <= 4'd10;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      i_q       <= '0;
      lv_q      <= '0;
      j_q       <= '0;
      base_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        fft_exp_q <= cfg_wdata_i;
      end
      cnt_q  <= cnt_d;
      done_q <= done_d;
      i_q    <= i_d;
      lv_q   <= lv_d;
      j_q    <= j_d;
      base_q <= base_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    echo_q <= echo_d;
    stat_q <= stat_d;
    if (state_q == r2fft_pkg::ST_BR_B) begin
      ra_q <= rdata_w;
    end
    if (state_q == r2fft_pkg::ST_TW) begin
      c_q <= c_d;
      s_q <= s_d;
    end
    if (state_q == r2fft_pkg::ST_BF_RDA) begin
      br_q <= rd_re_w;
      bi_q <= rd_im_w;
    end
    if (state_q == r2fft_pkg::ST_BF_M0) begin
      ar_q <= rd_re_w;
      ai_q <= rd_im_w;
    end
    p_q <= PW'(prod_w);
    case (state_q)
      r2fft_pkg::ST_BF_M1: acc_q <= p_q;
      r2fft_pkg::ST_BF_M3: acc_q <= p_q;
      default:             acc_q <= '0;
    endcase
    if (state_q == r2fft_pkg::ST_BF_M2) begin
      tr_q <= rsh_w[RW-1:0];
    end
    if (state_q == r2fft_pkg::ST_BF_M4) begin
      ti_q <= rsh_w[RW-1:0];
    end
  end

endmodule

@@ test/tb.sv @@
// Self-checking testbench for radix2_fft_engine_top: loads frames, reads bins, checks results.
// Depends on the top level and its RAM; all expected bins come from a bit-exact model in here.
`timescale 1ns / 100ps

module tb;

  localparam int NPTS_MAX = 1024;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic ST_VALID = 1'b0;
  localparam logic ST_NOT_READY = 1'b1;

  typedef struct packed {
    logic              op;
    logic signed [15:0] sample;
    logic [9:0]        bin;
  } fft_req_t;

  typedef struct packed {
    logic signed [25:0] re;
    logic signed [25:0] im;
    logic [9:0]         echo;
    logic               status;
  } bin_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic op_i = 1'b0;
  logic signed [15:0] sample_i = '0;
  logic [9:0] bin_index_i = '0;
  logic result_strobe_o;
  logic signed [25:0] bin_real_o, bin_imag_o;
  logic [9:0] bin_echo_o;
  logic status_o;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;

  radix2_fft_engine_top dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .sample_i, .bin_index_i,
    .result_strobe_o, .bin_real_o, .bin_imag_o, .bin_echo_o, .status_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always #4 clk_i = ~clk_i;

  // Model state of the engine.
  longint spec_re[NPTS_MAX];
  longint spec_im[NPTS_MAX];
  int unsigned fill_count;
  bit frame_ready;
  logic [3:0] size_log2;

  fft_req_t pending_reqs[$];
  bin_res_t expected_bins[$];
  fft_req_t cur_req;
  int errors = 0;
  int item_total = 0;
  bit no_idle = 1'b0;
  bit go;

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> sh);
  endfunction

  function automatic longint round_q62(logic [63:0] v);
    logic [63:0] t;
    t = (v + (64'd1 << 45)) >> 46;
    return longint'(t);
  endfunction

  // Twiddle cos and sin of 2*pi*u/2^32 in Q.16, from a Taylor series.
  task automatic twiddle(input logic [31:0] u, output longint c, output longint s);
    logic [31:0] r;
    logic [63:0] x, x2, cs, sn, tc, ts;
    bit swap;
    longint rc, rs, tmp;
    r = u & 32'h3FFFFFFF;
    swap = r > 32'h20000000;
    if (swap) r = 32'h40000000 - r;
    x = mul_shr(PI_Q60, {32'd0, r}, 29);
    x2 = mul_shr(x, x, 62);
    cs = ONE_Q62; tc = ONE_Q62; sn = x; ts = x;
    for (int k = 1; k <= 14; k++) begin
      tc = mul_shr(tc, x2, 62) / (64'(2 * k - 1) * 64'(2 * k));
      ts = mul_shr(ts, x2, 62) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2) begin
        cs = cs - tc; sn = sn - ts;
      end else begin
        cs = cs + tc; sn = sn + ts;
      end
    end
    rc = round_q62(cs);
    rs = round_q62(sn);
    if (swap) begin
      tmp = rc; rc = rs; rs = tmp;
    end
    if (u[31:30] != 0) begin
      tmp = rc; rc = -rs; rs = tmp;
    end
    c = rc;
    s = rs;
  endtask

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic int unsigned active_log2();
    if (size_log2 < 1) return 1;
    if (size_log2 > 10) return 10;
    return size_log2;
  endfunction

  // In-place bit reverse and butterfly stages over the model store.
  task automatic run_transform(input int unsigned e);
    int unsigned n, j, half;
    longint tmp, c, s, br, bi, tr, ti;
    n = 1 << e;
    for (int unsigned i = 0; i < n; i++) begin
      j = 0;
      for (int b = 0; b < e; b++) j |= ((i >> b) & 1) << (e - 1 - b);
      if (i < j) begin
        tmp = spec_re[i]; spec_re[i] = spec_re[j]; spec_re[j] = tmp;
        tmp = spec_im[i]; spec_im[i] = spec_im[j]; spec_im[j] = tmp;
      end
    end
    for (int unsigned lv = 1; lv <= e; lv++) begin
      half = 1 << (lv - 1);
      for (int unsigned t = 0; t < half; t++) begin
        twiddle(32'(t << (32 - lv)), c, s);
        for (int unsigned bs = t; bs + half < n; bs += 2 * half) begin
          br = spec_re[bs + half];
          bi = spec_im[bs + half];
          tr = (c * br + s * bi + 32768) >>> 16;
          ti = (c * bi - s * br + 32768) >>> 16;
          spec_re[bs + half] = clip(spec_re[bs] - tr, 27);
          spec_im[bs + half] = clip(spec_im[bs] - ti, 27);
          spec_re[bs] = clip(spec_re[bs] + tr, 27);
          spec_im[bs] = clip(spec_im[bs] + ti, 27);
        end
      end
    end
  endtask

  // Apply one accepted request to the model; reads queue an expected bin.
  task automatic predict_request(input fft_req_t rq);
    int unsigned e, n;
    bin_res_t exp_bin;
    e = active_log2();
    n = 1 << e;
    if (rq.op == OP_LOAD) begin
      if (frame_ready || fill_count >= n) begin
        frame_ready = 0;
        fill_count = 0;
      end
      spec_re[fill_count] = longint'(rq.sample);
      spec_im[fill_count] = 0;
      fill_count++;
      if (fill_count == n) begin
        run_transform(e);
        frame_ready = 1;
      end
    end else begin
      exp_bin.echo = rq.bin;
      if (!frame_ready) begin
        exp_bin.re = '0;
        exp_bin.im = '0;
        exp_bin.status = ST_NOT_READY;
      end else begin
        exp_bin.re = 26'(clip(spec_re[rq.bin & (n - 1)], 26));
        exp_bin.im = 26'(clip(spec_im[rq.bin & (n - 1)], 26));
        exp_bin.status = ST_VALID;
      end
      expected_bins.push_back(exp_bin);
    end
  endtask

  // Request driver: holds a request until it is taken, idles at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_request(cur_req);
      if (!(start && busy)) begin
        go = pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 15);
        if (go) begin
          cur_req = pending_reqs.pop_front();
          start <= 1'b1;
          op_i <= cur_req.op;
          sample_i <= cur_req.sample;
          bin_index_i <= cur_req.bin;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each strobe is compared with the oldest expected bin.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (expected_bins.size() == 0) begin
        $error("result with no request outstanding, bin_echo %0d", bin_echo_o);
        errors++;
      end else begin
        bin_res_t e;
        e = expected_bins.pop_front();
        if (bin_real_o !== e.re) begin
          $error("bin_real expected %0d actual %0d", e.re, bin_real_o); errors++;
        end
        if (bin_imag_o !== e.im) begin
          $error("bin_imag expected %0d actual %0d", e.im, bin_imag_o); errors++;
        end
        if (bin_echo_o !== e.echo) begin
          $error("bin_echo expected %0d actual %0d", e.echo, bin_echo_o); errors++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o); errors++;
        end
      end
    end
  end

  task automatic add_req(input logic op, input logic signed [15:0] smp, input logic [9:0] bin);
    fft_req_t rq;
    rq.op = op; rq.sample = smp; rq.bin = bin;
    pending_reqs.push_back(rq);
    item_total++;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Wait until every request is taken, every bin has come and the engine is quiet.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || start || expected_bins.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [3:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_log2 = v;
    fill_count = 0;
    frame_ready = 0;
  endtask

  // One frame of loads, or a partial frame, with a few early reads; a full frame is then followed by random bin reads.
  task automatic add_frame(input int unsigned n, input bit partial);
    int unsigned loads;
    loads = partial ? $urandom_range(1, n > 1 ? n - 1 : 1) : n;
    for (int unsigned i = 0; i < loads; i++) begin
      if ($urandom_range(0, 9) == 0) add_req(OP_READ, 16'($urandom), 10'($urandom));
      add_req(OP_LOAD, rand_sample(), 10'($urandom));
    end
    if (!partial)
      repeat ($urandom_range(2, 12)) add_req(OP_READ, 16'($urandom), 10'($urandom));
  endtask

  initial begin
    logic [3:0] nxt;
    int unsigned phase;
    fill_count = 0;
    frame_ready = 0;
    size_log2 = 4'd10;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 8 points, full-scale samples, early read, wrapped bin index.
    write_size(4'd3);
    add_req(OP_READ, 16'sh0000, 10'd5);
    add_req(OP_LOAD, 16'sh7FFF, 10'd0);
    add_req(OP_LOAD, 16'sh8000, 10'd0);
    add_req(OP_LOAD, 16'sh0000, 10'd0);
    add_req(OP_LOAD, 16'sh0001, 10'd0);
    add_req(OP_READ, 16'sh0000, 10'd0);
    add_req(OP_LOAD, 16'shFFFF, 10'd0);
    add_req(OP_LOAD, 16'sh7FFF, 10'd0);
    add_req(OP_LOAD, 16'sh7FFF, 10'd0);
    add_req(OP_LOAD, 16'sh8000, 10'd0);
    add_req(OP_READ, 16'sh0000, 10'd0);
    add_req(OP_READ, 16'sh0000, 10'd7);
    add_req(OP_READ, 16'shFFFF, 10'd1023);
    add_req(OP_READ, 16'sh0000, 10'd8);
    add_req(OP_READ, 16'sh0000, 10'd4);
    // A load after the frame is done starts a new frame.
    add_req(OP_LOAD, 16'sh1234, 10'd0);
    add_req(OP_READ, 16'sh0000, 10'd1);
    // Sender pauses until every result is back, then out-of-range exponents.
    drain();
    write_size(4'd0);
    add_frame(2, 0);
    write_size(4'd15);
    add_frame(1024, 0);

    // Random phases, mostly small frames, with a stretch without idling.
    phase = 0;
    while (item_total < 1950) begin
      case ($urandom_range(0, 19))
        0: nxt = 4'($urandom_range(7, 8));
        1: nxt = 4'd0;
        default: nxt = 4'($urandom_range(1, 6));
      endcase
      write_size(nxt);
      no_idle = (phase >= 6 && phase < 10);
      repeat ((active_log2() > 6) ? 1 : $urandom_range(1, 3))
        add_frame(1 << active_log2(), $urandom_range(0, 7) == 0);
      phase++;
    end
    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS radix2_fft_engine_top");
    end else begin
      $display("FAIL radix2_fft_engine_top");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #40ms;
    $display("FAIL radix2_fft_engine_top");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/r2fft_pkg.sv
hw/rtl/r2fft_ram.sv
hw/rtl/radix2_fft_engine_top.sv
test/tb.sv
